// ----- src/iss_pkg.sv -----
package iss_pkg;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned POS_W    = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_INSERT     = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_POP_BACK   = 3'd4,
    REQ_REMOVE     = 3'd5,
    REQ_READ       = 3'd6,
    REQ_SEARCH     = 3'd7
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // per-cell move
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_FROM_PREV = 2'd1,
    CELL_FROM_NEXT = 2'd2,
    CELL_LOAD      = 2'd3
  } cell_op_e;

  typedef struct packed {
    req_e                      req_type;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic                      found;
    logic [IDX_W-1:0]          found_position;
    logic [CNT_W-1:0]          count;
  } rsp_t;

endpackage

// ----- src/iss_cell.sv -----
module iss_cell
  import iss_pkg::*;
(
  input  logic              clk_i,
  input  cell_op_e          op_i,
  input  logic [DATA_W-1:0] prev_i,
  input  logic [DATA_W-1:0] next_i,
  input  logic [DATA_W-1:0] load_i,
  input  logic [DATA_W-1:0] key_i,
  output logic [DATA_W-1:0] data_o,
  output logic              match_o
);

  logic [DATA_W-1:0] data_q;
  logic [DATA_W-1:0] data_d;

  always_comb begin
    unique case (op_i)
      CELL_HOLD:      data_d = data_q;
      CELL_FROM_PREV: data_d = prev_i;
      CELL_FROM_NEXT: data_d = next_i;
      CELL_LOAD:      data_d = load_i;
      default:        data_d = data_q;
    endcase
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o  = data_q;
  assign match_o = (data_q == key_i);

endmodule

// ----- src/indexed_sequence_store_core.sv -----
// Ordered store of up to CAPACITY signed 32-bit values, addressed by index.
// Input channel in_*: one request item (type, position, value) per accept,
// accepted when in_valid_i is high and in_stall_o is low.
// Output channel out_*: exactly one result item per request (status, read
// value, found flag and index, count after the request).
// The result is registered: it is on out_o the cycle after the accept.
// Throughput: one item per cycle while in_stall_o is low. Every request is
// done as it is accepted: all cells of the chain shift at once for insert
// and remove, and all cells compare against the key at once for search.
// Backpressure: the result sits in an output register. A new request is
// taken while that register is empty or is being drained in the same
// cycle; while out_stall_i holds a waiting result, in_stall_o is high.
// Reset (rst_ni low, asynchronous) empties the store and drops any waiting
// result. The cell contents are not cleared; only entries below the count
// are ever read.
// Failed requests (range error, empty pop, full push) change nothing.
module indexed_sequence_store_core
  import iss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_o
);

  logic [CNT_W-1:0] occ_q, occ_d;
  logic             out_valid_q;
  rsp_t             out_q;
  rsp_t             rsp;
  logic             accept;

  // chain wiring
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_match;
  cell_op_e          cell_op [CAPACITY];

  // decoded request
  logic             do_open, do_close;
  logic [IDX_W-1:0] at;
  logic [CMP_W-1:0] pos_x, occ_x;
  logic [IDX_W-1:0] pos_idx;
  logic [CAPACITY-1:0] live_hit;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = out_valid_q && out_stall_i;

  assign pos_x   = CMP_W'(in_i.position);
  assign occ_x   = CMP_W'(occ_q);
  assign pos_idx = IDX_W'(in_i.position);

  // search hits restricted to live entries
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      live_hit[i] = cell_match[i] && (CNT_W'(i) < occ_q);
    end
  end

  always_comb begin
    do_open  = 1'b0;
    do_close = 1'b0;
    at       = '0;
    occ_d    = occ_q;
    rsp      = '0;
    rsp.status = ST_OK;

    unique case (in_i.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (occ_q >= CNT_W'(CAPACITY)) begin
          rsp.status = ST_FULL;
        end else begin
          do_open = 1'b1;
          at      = (in_i.req_type == REQ_PUSH_FRONT) ? '0 : IDX_W'(occ_q);
        end
      end
      REQ_INSERT: begin
        if (pos_x > occ_x) begin
          rsp.status = ST_RANGE;
        end else if (occ_q >= CNT_W'(CAPACITY)) begin
          rsp.status = ST_FULL;
        end else begin
          do_open = 1'b1;
          at      = pos_idx;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (occ_q == '0) begin
          rsp.status = ST_EMPTY;
        end else begin
          do_close = 1'b1;
          at       = (in_i.req_type == REQ_POP_FRONT) ? '0 : IDX_W'(occ_q - 1'b1);
        end
      end
      REQ_REMOVE: begin
        if (pos_x >= occ_x) begin
          rsp.status = ST_RANGE;
        end else begin
          do_close = 1'b1;
          at       = pos_idx;
        end
      end
      REQ_READ: begin
        if (pos_x >= occ_x) begin
          rsp.status = ST_RANGE;
        end else begin
          rsp.read_value = cell_data[pos_idx];
        end
      end
      REQ_SEARCH: begin
        // lowest live match wins
        for (int i = CAPACITY - 1; i >= 0; i--) begin
          if (live_hit[i]) begin
            rsp.found          = 1'b1;
            rsp.found_position = IDX_W'(i);
          end
        end
      end
      default: rsp.status = ST_OK;
    endcase

    if (do_open) begin
      occ_d = occ_q + 1'b1;
    end else if (do_close) begin
      occ_d = occ_q - 1'b1;
    end
    rsp.count = occ_d;
  end

  // per-cell moves: open shifts up above the gap, close shifts down from it
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_op[i] = CELL_HOLD;
      if (accept && do_open) begin
        if (IDX_W'(i) == at) begin
          cell_op[i] = CELL_LOAD;
        end else if (IDX_W'(i) > at) begin
          cell_op[i] = CELL_FROM_PREV;
        end
      end else if (accept && do_close) begin
        if (IDX_W'(i) >= at) begin
          cell_op[i] = CELL_FROM_NEXT;
        end
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_w = cell_data[g];
    end else begin : g_inner
      assign next_w = cell_data[g+1];
    end

    iss_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_op[g]),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .load_i  (in_i.value),
      .key_i   (in_i.value),
      .data_o  (cell_data[g]),
      .match_o (cell_match[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q       <= occ_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // count never exceeds the number of cells
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // reported count matches the stored count right after the request
  a_count_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_valid_q && out_q.count == occ_q))
    else $error("result count differs from occupancy");

  // a failed request leaves the count alone
  a_fail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && rsp.status != ST_OK) |=> (occ_q == $past(occ_q)))
    else $error("failed request changed occupancy");

  // successful open grows the count by one
  a_open_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && do_open) |=> (occ_q == $past(occ_q) + 1'b1))
    else $error("push or insert did not grow occupancy");

  // no found index without a hit
  a_found_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.found) |-> (out_q.found_position == '0))
    else $error("found_position set without a match");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb
  import iss_pkg::*;
();

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned QUIET_ITEMS  = 200;   // tail of the run with no idling
  localparam int unsigned LONG_HOLD    = 60;    // receiver hold-off, fills the block
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned PAUSE_AT     = 800;
  localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no item moving

  // biases the random request mix so the store swings between empty and full
  typedef enum int unsigned {
    MIX_ANY,
    MIX_FILL,
    MIX_DRAIN
  } traffic_e;

  typedef struct packed {
    req_t req;
    bit   typed;   // want holds a hand-written result
    rsp_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_req;
  logic out_valid;
  logic out_stall;
  rsp_t out_rsp;

  indexed_sequence_store_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_rsp)
  );

  // shadow copy of the store, advanced once per accepted request
  logic signed [DATA_W-1:0] shadow_cells [CAPACITY];
  int unsigned              shadow_count;

  rsp_t        pending_rsp_q [$];
  stim_row_t   directed_rows [$];
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  bit          hold_long;
  bit          quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Works out the result of one request and applies it to the shadow store.
  // Failed requests leave the shadow untouched.
  function automatic rsp_t apply_request(req_t r);
    rsp_t        o;
    bit          grow;
    bit          shrink;
    int unsigned at;
    o        = '0;
    o.status = ST_OK;
    grow     = 1'b0;
    shrink   = 1'b0;
    at       = 0;
    case (r.req_type)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          grow = 1'b1;
          at   = (r.req_type == REQ_PUSH_FRONT) ? 0 : shadow_count;
        end
      end
      REQ_INSERT: begin
        // range is checked ahead of the full check
        if (r.position > shadow_count) begin
          o.status = ST_RANGE;
        end else if (shadow_count >= CAPACITY) begin
          o.status = ST_FULL;
        end else begin
          grow = 1'b1;
          at   = r.position;
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          shrink = 1'b1;
          at     = (r.req_type == REQ_POP_FRONT) ? 0 : shadow_count - 1;
        end
      end
      REQ_REMOVE: begin
        if (r.position >= shadow_count) begin
          o.status = ST_RANGE;
        end else begin
          shrink = 1'b1;
          at     = r.position;
        end
      end
      REQ_READ: begin
        if (r.position >= shadow_count) begin
          o.status = ST_RANGE;
        end else begin
          o.read_value = shadow_cells[r.position];
        end
      end
      default: begin
        // lowest matching index wins
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_cells[i] == r.value) begin
            o.found          = 1'b1;
            o.found_position = IDX_W'(i);
            break;
          end
        end
      end
    endcase
    if (grow) begin
      for (int i = shadow_count; i > at; i--) shadow_cells[i] = shadow_cells[i - 1];
      shadow_cells[at] = r.value;
      shadow_count++;
    end
    if (shrink) begin
      for (int i = at; i + 1 < shadow_count; i++) shadow_cells[i] = shadow_cells[i + 1];
      shadow_count--;
    end
    o.count = CNT_W'(shadow_count);
    return o;
  endfunction

  function automatic req_t make_random_request(traffic_e mix);
    req_t        r;
    int unsigned roll;
    r    = '0;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  r.req_type = (roll < 70) ? req_e'($urandom_range(REQ_PUSH_FRONT, REQ_INSERT))
                                          : req_e'($urandom_range(REQ_PUSH_FRONT, REQ_SEARCH));
      MIX_DRAIN: r.req_type = (roll < 70) ? req_e'($urandom_range(REQ_POP_FRONT, REQ_REMOVE))
                                          : req_e'($urandom_range(REQ_PUSH_FRONT, REQ_SEARCH));
      default:   r.req_type = req_e'($urandom_range(REQ_PUSH_FRONT, REQ_SEARCH));
    endcase
    // mostly legal indexes, one past the end now and then, plus full-field noise
    if ($urandom_range(0, 3) != 0) begin
      r.position = POS_W'($urandom_range(0, shadow_count));
    end else begin
      r.position = POS_W'($urandom_range(0, (1 << POS_W) - 1));
    end
    roll = $urandom_range(0, 99);
    if (r.req_type == REQ_SEARCH && shadow_count != 0 && roll < 60) begin
      r.value = shadow_cells[$urandom_range(0, shadow_count - 1)];
    end else if (roll < 70) begin
      r.value = $urandom_range(0, 7);  // few distinct values -> duplicates, search hits
    end else if (roll < 85) begin
      case ($urandom_range(0, 3))
        0:       r.value = 32'sh8000_0000;
        1:       r.value = 32'sh7fff_ffff;
        2:       r.value = '1;
        default: r.value = '0;
      endcase
    end else begin
      r.value = $urandom;
    end
    return r;
  endfunction

  task automatic add_case(input req_e kind, input int pos, input logic signed [DATA_W-1:0] v,
                          input bit typed, input status_e st,
                          input logic signed [DATA_W-1:0] rd, input int cnt);
    stim_row_t row;
    row                  = '0;
    row.req.req_type     = kind;
    row.req.position     = POS_W'(pos);
    row.req.value        = v;
    row.typed            = typed;
    row.want.status      = st;
    row.want.read_value  = rd;
    row.want.count       = CNT_W'(cnt);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Offers one item, holds it steady until taken, then records its result.
  task automatic send_item(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(r);
    pending_rsp_q.insert(pending_rsp_q.size(), typed ? want : predicted);
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    mismatch_count++;
  endtask

  // sender: reset, directed table, then biased random traffic
  initial begin : in_side
    traffic_e    mix;
    int unsigned mix_left;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_req         <= '0;
    shadow_count   = 0;
    mismatch_count = 0;
    hold_long      = 1'b0;
    quiet          = 1'b0;
    mix            = MIX_ANY;
    mix_left       = 0;

    // empty store: every removal and index access fails
    add_case(REQ_POP_FRONT,  0, 0,              1, ST_EMPTY, 0, 0);
    add_case(REQ_POP_BACK,   0, 0,              1, ST_EMPTY, 0, 0);
    add_case(REQ_REMOVE,     0, 0,              1, ST_RANGE, 0, 0);
    add_case(REQ_READ,       0, 0,              1, ST_RANGE, 0, 0);
    add_case(REQ_INSERT,     1, 5,              1, ST_RANGE, 0, 0);
    add_case(REQ_SEARCH,     0, 0,              1, ST_OK,    0, 0);
    // build [-1, max, min, 0] through every way of adding
    add_case(REQ_INSERT,     0, 32'sh7fff_ffff, 1, ST_OK,    0, 1);
    add_case(REQ_PUSH_BACK,  0, 32'sh8000_0000, 1, ST_OK,    0, 2);
    add_case(REQ_PUSH_FRONT, 0, -1,             1, ST_OK,    0, 3);
    add_case(REQ_INSERT,     3, 0,              1, ST_OK,    0, 4);
    add_case(REQ_READ,       0, 0,              1, ST_OK,    -1, 4);
    add_case(REQ_READ,       1, 0,              1, ST_OK,    32'sh7fff_ffff, 4);
    add_case(REQ_READ,       2, 0,              1, ST_OK,    32'sh8000_0000, 4);
    add_case(REQ_READ,       4, 0,              1, ST_RANGE, 0, 4);
    add_case(REQ_READ,       31, 0,             1, ST_RANGE, 0, 4);
    add_case(REQ_INSERT,     31, 7,             1, ST_RANGE, 0, 4);
    add_case(REQ_REMOVE,     4, 0,              1, ST_RANGE, 0, 4);
    // duplicate max: search must report the lower index
    add_case(REQ_PUSH_BACK,  0, 32'sh7fff_ffff, 0, ST_OK, 0, 0);
    add_case(REQ_SEARCH,     0, 32'sh7fff_ffff, 0, ST_OK, 0, 0);
    add_case(REQ_SEARCH,     0, 12345,          0, ST_OK, 0, 0);
    add_case(REQ_SEARCH,     0, 0,              0, ST_OK, 0, 0);
    add_case(REQ_REMOVE,     1, 0,              0, ST_OK, 0, 0);
    add_case(REQ_POP_FRONT,  0, 0,              0, ST_OK, 0, 0);
    add_case(REQ_POP_BACK,   0, 0,              0, ST_OK, 0, 0);
    add_case(REQ_INSERT,     1, 32'sh5555_5555, 0, ST_OK, 0, 0);
    add_case(REQ_READ,       1, 0,              0, ST_OK, 0, 0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) send_item(directed_rows[i].req, directed_rows[i].typed,
                                         directed_rows[i].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      // receiver holds off while items keep coming, backing up the input
      if (n == HOLD_AT) hold_long = 1'b1;
      // let the pipe run dry before carrying on
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge clk);
      end
      if (mix_left == 0) begin
        mix      = traffic_e'($urandom_range(MIX_ANY, MIX_DRAIN));
        mix_left = $urandom_range(20, 60);
      end
      mix_left--;
      send_item(make_random_request(mix), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);  // catch any stray result
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // receiver: random stall bursts, clear runs, one long hold-off on request
  initial begin : out_side
    int unsigned span;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        repeat (span) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  // result check against the oldest outstanding expectation
  always @(posedge clk) begin : result_check
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t: result with nothing expected, got status %0d count %0d",
                 $time, out_rsp.status, out_rsp.count);
        mismatch_count++;
      end else begin
        want = pending_rsp_q[0];
        pending_rsp_q.delete(0);
        if (out_rsp.status !== want.status)
          report_field("status", want.status, out_rsp.status);
        if (out_rsp.read_value !== want.read_value)
          report_field("read_value", want.read_value, out_rsp.read_value);
        if (out_rsp.found !== want.found)
          report_field("found", want.found, out_rsp.found);
        if (out_rsp.found_position !== want.found_position)
          report_field("found_position", want.found_position, out_rsp.found_position);
        if (out_rsp.count !== want.count)
          report_field("count", want.count, out_rsp.count);
      end
    end
  end

  // watchdog: any accepted item on either side counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
